@@ src/dfpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpa_pkg
// Shared types and constants of the decimal fixed-point ALU.
// ----------------------------------------------------------------------------
package dfpa_pkg;

  localparam int QBITS   = 64;
  localparam int LATENCY = QBITS + 3;

  localparam logic [2:0] ACT_ADD      = 3'd0;
  localparam logic [2:0] ACT_SUB      = 3'd1;
  localparam logic [2:0] ACT_MUL      = 3'd2;
  localparam logic [2:0] ACT_DIV      = 3'd3;
  localparam logic [2:0] ACT_FROM_INT = 3'd4;
  localparam logic [2:0] ACT_TO_INT   = 3'd5;

  localparam logic signed [31:0] FX_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic              valid;
    logic [QBITS-1:0]  nq;      // dividend bits shifted out, quotient bits shifted in
    logic [31:0]       rem;
    logic [31:0]       dvs;
    logic              neg;     // quotient sign
    logic              dz;      // division by zero
    logic              dz_pos;  // dividend nonnegative for division by zero
    logic              zero;    // unused action code
  } cell_t;

endpackage

@@ src/dfpa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpa_front
// Two stages: multiply or add, then dividend and divisor magnitudes.
// ----------------------------------------------------------------------------
module dfpa_front #(
  parameter int SCALE = 1000
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2:0]          action,
  input  logic signed [31:0]  operand_a,
  input  logic signed [31:0]  operand_b,
  output dfpa_pkg::cell_t     cell_out
);

  localparam logic signed [31:0] SCALE_S = 32'(SCALE);

  logic               s1_valid;
  logic [2:0]         s1_act;
  logic signed [63:0] s1_prod;
  logic signed [63:0] s1_sum;
  logic signed [31:0] s1_a;
  logic signed [31:0] s1_b;

  logic signed [31:0] mul_b;
  logic signed [63:0] num;
  logic signed [31:0] den;

  always_comb begin
    mul_b = (action == dfpa_pkg::ACT_MUL) ? operand_b : SCALE_S;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_act  <= action;
    s1_prod <= operand_a * mul_b;
    s1_sum  <= (action == dfpa_pkg::ACT_SUB)
               ? (64'(operand_a) - 64'(operand_b)) : (64'(operand_a) + 64'(operand_b));
    s1_a    <= operand_a;
    s1_b    <= operand_b;
  end

  always_comb begin
    case (s1_act)
      dfpa_pkg::ACT_ADD, dfpa_pkg::ACT_SUB: begin
        num = s1_sum;
        den = 32'sd1;
      end
      dfpa_pkg::ACT_MUL: begin
        num = s1_prod;
        den = SCALE_S;
      end
      dfpa_pkg::ACT_DIV: begin
        num = s1_prod;
        den = s1_b;
      end
      dfpa_pkg::ACT_FROM_INT: begin
        num = s1_prod;
        den = 32'sd1;
      end
      dfpa_pkg::ACT_TO_INT: begin
        num = 64'(s1_a);
        den = SCALE_S;
      end
      default: begin
        num = '0;
        den = 32'sd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= s1_valid;
    end
    cell_out.nq     <= num[63] ? 64'(-num) : 64'(num);
    cell_out.rem    <= '0;
    cell_out.dvs    <= den[31] ? 32'(-den) : 32'(den);
    cell_out.neg    <= num[63] ^ den[31];
    cell_out.dz     <= (s1_act == dfpa_pkg::ACT_DIV) && (s1_b == 32'sd0);
    cell_out.dz_pos <= !s1_a[31];
    cell_out.zero   <= (s1_act > dfpa_pkg::ACT_TO_INT);
  end

endmodule

@@ src/dfpa_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpa_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module dfpa_cell (
  input  logic            clk,
  input  logic            rst,
  input  dfpa_pkg::cell_t cell_in,
  output dfpa_pkg::cell_t cell_out
);

  logic [32:0] trial;
  logic        ge;
  logic [32:0] rem_next;

  always_comb begin
    trial    = {cell_in.rem, cell_in.nq[dfpa_pkg::QBITS-1]};
    ge       = trial >= {1'b0, cell_in.dvs};
    rem_next = ge ? (trial - {1'b0, cell_in.dvs}) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= cell_in.valid;
    end
    cell_out.nq     <= {cell_in.nq[dfpa_pkg::QBITS-2:0], ge};
    cell_out.rem    <= rem_next[31:0];
    cell_out.dvs    <= cell_in.dvs;
    cell_out.neg    <= cell_in.neg;
    cell_out.dz     <= cell_in.dz;
    cell_out.dz_pos <= cell_in.dz_pos;
    cell_out.zero   <= cell_in.zero;
  end

endmodule

@@ src/decimal_fixed_point_alu_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_fixed_point_alu_top
// Saturating decimal fixed-point ALU with a pipelined divider chain.
// ----------------------------------------------------------------------------
// Pipeline: 2 front stages, 64 divider cells, one output register.
// Throughput: one transfer per cycle; busy stays low, the chain never stalls.
// Reset: synchronous, clears every valid flag; the receiver cannot stall.
// ----------------------------------------------------------------------------
module decimal_fixed_point_alu_top #(
  parameter int SCALE = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               done,
  output logic signed [31:0] result
);

  // Every operation is recast as a signed quotient: sums and integer scaling
  // divide by one, mul and to_int divide by the scale, div by operand_b.
  // The chain works on magnitudes; sign and saturation are applied at the end.
  dfpa_pkg::cell_t chain [0:dfpa_pkg::QBITS];

  logic [63:0]        quo;
  logic signed [31:0] res_next;

  assign busy = 1'b0;

  dfpa_front #(.SCALE(SCALE)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .action   (action),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .cell_out (chain[0])
  );

  for (genvar i = 0; i < dfpa_pkg::QBITS; i++) begin : g_cell
    dfpa_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_in (chain[i]),
      .cell_out(chain[i+1])
    );
  end

  // Zero unused actions, saturate divide by zero, else clamp by quotient sign.
  always_comb begin
    quo = chain[dfpa_pkg::QBITS].nq;
    if (chain[dfpa_pkg::QBITS].zero) begin
      res_next = '0;
    end else if (chain[dfpa_pkg::QBITS].dz) begin
      res_next = chain[dfpa_pkg::QBITS].dz_pos ? dfpa_pkg::FX_MAX : dfpa_pkg::FX_MIN;
    end else if (chain[dfpa_pkg::QBITS].neg) begin
      res_next = (quo > 64'h8000_0000) ? dfpa_pkg::FX_MIN : 32'(-quo);
    end else begin
      res_next = (quo > 64'h7FFF_FFFF) ? dfpa_pkg::FX_MAX : 32'(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[dfpa_pkg::QBITS].valid;
    end
    result <= res_next;
  end

endmodule

@@ src/dfpa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpa_checker
// Port-level checks of the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module dfpa_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [2:0]         action,
  input logic signed [31:0] operand_a,
  input logic signed [31:0] operand_b,
  input logic               done,
  input logic signed [31:0] result
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy asserted");

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(dfpa_pkg::LATENCY) done)
    else $error("result missing after transfer");

  a_div_zero_pos: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == dfpa_pkg::ACT_DIV && operand_b == 32'sd0
     && !operand_a[31]) |-> ##(dfpa_pkg::LATENCY) (result == dfpa_pkg::FX_MAX))
    else $error("division by zero not saturated");

  a_bad_action: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action > dfpa_pkg::ACT_TO_INT)
    |-> ##(dfpa_pkg::LATENCY) (result == 32'sd0))
    else $error("unused action gave nonzero result");

endmodule

bind decimal_fixed_point_alu_top dfpa_checker u_dfpa_checker (.*);
